// ===== rtl/ppvs_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package ppvs_pkg;

    localparam int MAX_ENTRIES = 4096;
    localparam int VALUE_BITS = 16;
    localparam int PAL_BITS = 8;
    localparam int PAL_DEPTH = 256;
    localparam int DATA_WORDS = 1024;
    localparam int WORD_BITS = 64;

    localparam logic [1:0] CMD_GET = 2'd0;
    localparam logic [1:0] CMD_SET = 2'd1;
    localparam logic [1:0] CMD_FILL = 2'd2;

    localparam logic [1:0] CFG_ENTRY_COUNT = 2'd0;
    localparam logic [1:0] CFG_MIN_BITS = 2'd1;
    localparam logic [1:0] CFG_MAX_BITS = 2'd2;
    localparam logic [1:0] CFG_DIRECT_BITS = 2'd3;

    typedef enum logic [1:0] {
        MODE_SINGLE = 2'd0,
        MODE_PALETTE = 2'd1,
        MODE_DIRECT = 2'd2
    } mode_t;

    typedef enum logic [4:0] {
        S_IDLE,
        S_DECODE,
        S_NEW_P0,
        S_NEW_P1,
        S_PSRCH_A,
        S_PSRCH_C,
        S_LOC_GO,
        S_LOC,
        S_WRD,
        S_WDAT,
        S_PDAT,
        S_RB_INIT,
        S_RB_WRD,
        S_RB_WDAT,
        S_RB_PDAT,
        S_RB_SA,
        S_RB_SC,
        S_RB_SNAP,
        S_RB_DECIDE,
        S_RB_P2A,
        S_RB_P2D,
        S_CLR,
        S_DONE
    } state_t;

    // packed position of one entry
    typedef struct packed {
        logic [9:0] word;
        logic [5:0] shift;
    } loc_t;

    // entries per 64-bit word
    function automatic logic [6:0] per_of(input logic [4:0] w);
        logic [6:0] p;
        begin
            case (w)
                5'd1: p = 7'd64;
                5'd2: p = 7'd32;
                5'd3: p = 7'd21;
                5'd4: p = 7'd16;
                5'd5: p = 7'd12;
                5'd6: p = 7'd10;
                5'd7: p = 7'd9;
                5'd8: p = 7'd8;
                5'd9: p = 7'd7;
                5'd10: p = 7'd6;
                5'd11: p = 7'd5;
                5'd12: p = 7'd5;
                default: p = 7'd4;
            endcase
            return p;
        end
    endfunction

    // floor(65536 / per_of(w))
    function automatic logic [14:0] recip_of(input logic [4:0] w);
        logic [14:0] r;
        begin
            case (w)
                5'd1: r = 15'd1024;
                5'd2: r = 15'd2048;
                5'd3: r = 15'd3120;
                5'd4: r = 15'd4096;
                5'd5: r = 15'd5461;
                5'd6: r = 15'd6553;
                5'd7: r = 15'd7281;
                5'd8: r = 15'd8192;
                5'd9: r = 15'd9362;
                5'd10: r = 15'd10922;
                5'd11: r = 15'd13107;
                5'd12: r = 15'd13107;
                default: r = 15'd16384;
            endcase
            return r;
        end
    endfunction

    function automatic logic [63:0] wmask(input logic [4:0] w);
        logic [64:0] t;
        begin
            t = (65'd1 << w) - 65'd1;
            return t[63:0];
        end
    endfunction

    function automatic logic [3:0] clamp_pal(input logic [3:0] v);
        begin
            if (v == 4'd0) return 4'd1;
            if (v > 4'd8) return 4'd8;
            return v;
        end
    endfunction

    function automatic logic [4:0] clamp_dir(input logic [4:0] v);
        begin
            if (v == 5'd0) return 5'd1;
            if (v > 5'd16) return 5'd16;
            return v;
        end
    endfunction

    // smallest b with 2^b >= count
    function automatic logic [3:0] bits_for(input logic [8:0] count);
        logic [3:0] b;
        begin
            b = 4'd8;
            for (int i = 8; i >= 0; i--) begin
                if ((9'd1 << i) >= count) b = 4'(i);
            end
            return b;
        end
    endfunction

endpackage

`default_nettype wire

// ===== rtl/ppvs_locate.sv =====
`timescale 1ns / 1ps
`default_nettype none

// entry index -> word and bit offset, pipelined, reciprocal divide
module ppvs_locate import ppvs_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       start,
    input  wire logic [11:0] index,
    input  wire logic [4:0] width,
    output logic            done,
    output loc_t            loc
);

    logic        v1_reg, v2_reg, v3_reg, v4_reg;
    logic [26:0] prod_reg;
    logic [11:0] idx_reg;
    logic [4:0]  w_reg;
    logic [6:0]  per_reg;
    logic [9:0]  q0_reg;
    logic [7:0]  rem_reg;
    logic [9:0]  word_reg;
    logic [5:0]  r_reg;
    logic [5:0]  shift_reg;

    logic [16:0] qp;
    logic [11:0] diff;
    logic [10:0] rw;

    always_comb
    begin
        qp = 17'(prod_reg[25:16]) * 17'(per_reg);
        diff = idx_reg - qp[11:0];
        rw = 11'(r_reg) * 11'(w_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= start;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            prod_reg <= 27'(index) * 27'(recip_of(width));
            idx_reg <= index;
            w_reg <= width;
            per_reg <= per_of(width);
        end
        q0_reg <= prod_reg[25:16];
        rem_reg <= diff[7:0];
        // estimate is low by at most one
        if ({1'b0, rem_reg} >= {2'b0, per_reg})
        begin
            word_reg <= q0_reg + 10'd1;
            r_reg <= 6'(rem_reg - {1'b0, per_reg});
        end
        else
        begin
            word_reg <= q0_reg;
            r_reg <= rem_reg[5:0];
        end
        shift_reg <= rw[5:0];
    end

    assign done = v4_reg;
    assign loc.word = word_reg;
    assign loc.shift = shift_reg;

endmodule

`default_nettype wire

// ===== rtl/paletted_packed_value_store_unit.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Channel | Signals                                   | Beat taken when
// --------+-------------------------------------------+-------------------------
// in      | in_valid in_stall command entry_index      | in_valid && !in_stall
//         | entry_value                               |
// out     | out_valid out_stall read_value storage_mode| out_valid && !out_stall
//         | bits_per_entry palette_entries            |
// cfg     | cfg_valid cfg_ready cfg_index cfg_data     | cfg_valid && cfg_ready
//
// One command at a time. Get in single mode returns the stored value;
// otherwise it runs the locate unit, a packed word read and, in palette
// mode, a palette read. Set in palette mode searches the palette entry by
// entry. Leaving single mode clears a 1024-word bank. A rebuild walks every
// entry twice.
// Reset initialises mode and control registers only; memories need no clearing pass.
// A waiting result in the output register does not block the next beat.
module paletted_packed_value_store_unit import ppvs_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic [1:0]  command,
    input  wire logic [11:0] entry_index,
    input  wire logic [15:0] entry_value,
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic [15:0]      read_value,
    output logic [1:0]       storage_mode,
    output logic [4:0]       bits_per_entry,
    output logic [8:0]       palette_entries,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [15:0] cfg_data
);

    // control state
    state_t      state_reg, state_next;
    logic [12:0] cnt_cfg_reg, cnt_cfg_next;
    logic [3:0]  min_cfg_reg, min_cfg_next;
    logic [3:0]  max_cfg_reg, max_cfg_next;
    logic [4:0]  dir_cfg_reg, dir_cfg_next;
    mode_t       mode_reg, mode_next;
    logic [4:0]  width_reg, width_next;
    logic [15:0] single_reg, single_next;
    logic [8:0]  used_reg, used_next;
    logic        pk_bank_reg, pk_bank_next;
    logic        pal_bank_reg, pal_bank_next;
    logic        out_valid_reg, out_valid_next;

    // working registers
    logic [1:0]  cmd_reg, cmd_next;
    logic [11:0] idx_reg, idx_next;
    logic [15:0] val_reg, val_next;
    logic [4:0]  loc_w_reg, loc_w_next;
    logic [9:0]  word_reg, word_next;
    logic [5:0]  shift_reg, shift_next;
    logic [15:0] found_reg, found_next;
    logic [8:0]  k_reg, k_next;
    logic [15:0] rd_reg, rd_next;
    logic [15:0] o_val_reg, o_val_next;
    mode_t       o_mode_reg, o_mode_next;
    logic [4:0]  o_bits_reg, o_bits_next;
    logic [8:0]  o_pal_reg, o_pal_next;
    logic [11:0] e_reg, e_next;
    logic [9:0]  wc_reg, wc_next;
    logic [5:0]  slot_reg, slot_next;
    logic [5:0]  sh_reg, sh_next;
    logic [8:0]  count_reg, count_next;
    logic        ovf_reg, ovf_next;
    logic [15:0] v_reg, v_next;
    logic [7:0]  snidx_reg, snidx_next;
    logic [15:0] first_reg, first_next;
    logic [4:0]  new_w_reg, new_w_next;
    logic [63:0] acc_reg, acc_next;
    logic [10:0] ctr_reg, ctr_next;
    logic        hit_en_reg, hit_en_next;
    logic [9:0]  hit_word_reg, hit_word_next;
    logic [63:0] hit_data_reg, hit_data_next;
    mode_t       nx_mode_reg, nx_mode_next;
    logic [8:0]  nx_used_reg, nx_used_next;
    logic        swap_pal_reg, swap_pal_next;

    // memories: two packed banks, two palette banks, rebuild snapshot
    logic [63:0] pk_mem [2*DATA_WORDS];
    logic [15:0] pal_mem [2*PAL_DEPTH];
    logic [23:0] snap_mem [MAX_ENTRIES];
    logic [63:0] pk_rdata_reg;
    logic [15:0] pal_rdata_reg;
    logic [23:0] snap_rdata_reg;

    logic        pk_we, pal_we, snap_we;
    logic [10:0] pk_waddr, pk_raddr;
    logic [63:0] pk_wdata;
    logic [8:0]  pal_waddr, pal_raddr;
    logic [15:0] pal_wdata;
    logic [11:0] snap_waddr, snap_raddr;
    logic [23:0] snap_wdata;

    logic        loc_start, loc_done;
    loc_t        loc;

    ppvs_locate u_locate (
        .clk   (clk),
        .rst_n (rst_n),
        .start (loc_start),
        .index (idx_reg),
        .width (loc_w_reg),
        .done  (loc_done),
        .loc   (loc)
    );

    always_ff @(posedge clk)
    begin
        if (pk_we) pk_mem[pk_waddr] <= pk_wdata;
        pk_rdata_reg <= pk_mem[pk_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (pal_we) pal_mem[pal_waddr] <= pal_wdata;
        pal_rdata_reg <= pal_mem[pal_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (snap_we) snap_mem[snap_waddr] <= snap_wdata;
        snap_rdata_reg <= snap_mem[snap_raddr];
    end

    logic [12:0] n_ent;
    logic [4:0]  w_dir;
    logic [3:0]  w_lo;
    logic [8:0]  limit;
    logic [63:0] mask_w, mask_new, fld64, acc_add;
    logic [6:0]  per_old, per_new;
    logic        idx_ok, e_last;
    logic [16:0] vmask;
    logic [3:0]  bf;
    logic [15:0] p2_fld;

    always_comb
    begin
        if (cnt_cfg_reg == 13'd0) n_ent = 13'd1;
        else if (cnt_cfg_reg > 13'(MAX_ENTRIES)) n_ent = 13'(MAX_ENTRIES);
        else n_ent = cnt_cfg_reg;
        w_dir = clamp_dir(dir_cfg_reg);
        w_lo = clamp_pal(min_cfg_reg);
        limit = 9'd1 << clamp_pal(max_cfg_reg);
        vmask = (17'd1 << w_dir) - 17'd1;
        mask_w = wmask(width_reg);
        mask_new = wmask(new_w_reg);
        per_old = per_of(width_reg);
        per_new = per_of(new_w_reg);
        idx_ok = {1'b0, idx_reg} < n_ent;
        e_last = {1'b0, e_reg} == (n_ent - 13'd1);
        fld64 = (pk_rdata_reg >> shift_reg) & mask_w;
        bf = bits_for(count_reg);
        p2_fld = ovf_reg ? snap_rdata_reg[15:0] : {8'd0, snap_rdata_reg[23:16]};
        acc_add = (64'(p2_fld) & mask_new) << sh_reg;
    end

    always_comb
    begin
        state_next = state_reg;
        cnt_cfg_next = cnt_cfg_reg;
        min_cfg_next = min_cfg_reg;
        max_cfg_next = max_cfg_reg;
        dir_cfg_next = dir_cfg_reg;
        mode_next = mode_reg;
        width_next = width_reg;
        single_next = single_reg;
        used_next = used_reg;
        pk_bank_next = pk_bank_reg;
        pal_bank_next = pal_bank_reg;
        out_valid_next = out_valid_reg;
        cmd_next = cmd_reg;
        idx_next = idx_reg;
        val_next = val_reg;
        loc_w_next = loc_w_reg;
        word_next = word_reg;
        shift_next = shift_reg;
        found_next = found_reg;
        k_next = k_reg;
        rd_next = rd_reg;
        o_val_next = o_val_reg;
        o_mode_next = o_mode_reg;
        o_bits_next = o_bits_reg;
        o_pal_next = o_pal_reg;
        e_next = e_reg;
        wc_next = wc_reg;
        slot_next = slot_reg;
        sh_next = sh_reg;
        count_next = count_reg;
        ovf_next = ovf_reg;
        v_next = v_reg;
        snidx_next = snidx_reg;
        first_next = first_reg;
        new_w_next = new_w_reg;
        acc_next = acc_reg;
        ctr_next = ctr_reg;
        hit_en_next = hit_en_reg;
        hit_word_next = hit_word_reg;
        hit_data_next = hit_data_reg;
        nx_mode_next = nx_mode_reg;
        nx_used_next = nx_used_reg;
        swap_pal_next = swap_pal_reg;
        pk_we = 1'b0;
        pk_waddr = {pk_bank_reg, word_reg};
        pk_wdata = 64'd0;
        pk_raddr = {pk_bank_reg, word_reg};
        pal_we = 1'b0;
        pal_waddr = {pal_bank_reg, 8'd0};
        pal_wdata = val_reg;
        pal_raddr = {pal_bank_reg, k_reg[7:0]};
        snap_we = 1'b0;
        snap_waddr = e_reg;
        snap_wdata = {snidx_reg, v_reg};
        snap_raddr = e_reg;
        loc_start = 1'b0;

        if (cfg_valid)
        begin
            case (cfg_index)
                CFG_ENTRY_COUNT: cnt_cfg_next = cfg_data[12:0];
                CFG_MIN_BITS: min_cfg_next = cfg_data[3:0];
                CFG_MAX_BITS: max_cfg_next = cfg_data[3:0];
                CFG_DIRECT_BITS: dir_cfg_next = cfg_data[4:0];
                default: ;
            endcase
        end

        if (out_valid_reg && !out_stall) out_valid_next = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd_next = command;
                    idx_next = entry_index;
                    val_next = entry_value & vmask[15:0];
                    state_next = S_DECODE;
                end
            end
            S_DECODE:
            begin
                rd_next = 16'd0;
                state_next = S_DONE;
                case (cmd_reg)
                    CMD_GET:
                    begin
                        if (idx_ok)
                        begin
                            if (mode_reg == MODE_SINGLE) rd_next = single_reg;
                            else
                            begin
                                loc_w_next = width_reg;
                                state_next = S_LOC_GO;
                            end
                        end
                    end
                    CMD_SET:
                    begin
                        if (idx_ok)
                        begin
                            case (mode_reg)
                                MODE_SINGLE:
                                begin
                                    if (val_reg != single_reg)
                                    begin
                                        loc_w_next = {1'b0, w_lo};
                                        state_next = S_NEW_P0;
                                    end
                                end
                                MODE_DIRECT:
                                begin
                                    found_next = val_reg;
                                    loc_w_next = width_reg;
                                    state_next = S_LOC_GO;
                                end
                                default:
                                begin
                                    k_next = 9'd0;
                                    state_next = S_PSRCH_A;
                                end
                            endcase
                        end
                    end
                    CMD_FILL:
                    begin
                        mode_next = MODE_SINGLE;
                        width_next = 5'd0;
                        single_next = val_reg;
                        used_next = 9'd0;
                    end
                    default: ;
                endcase
            end
            // two-entry palette: old single value, then the new one
            S_NEW_P0:
            begin
                pal_we = 1'b1;
                pal_waddr = {pal_bank_reg, 8'd0};
                pal_wdata = single_reg;
                state_next = S_NEW_P1;
            end
            S_NEW_P1:
            begin
                pal_we = 1'b1;
                pal_waddr = {pal_bank_reg, 8'd1};
                pal_wdata = val_reg;
                found_next = 16'd1;
                state_next = S_LOC_GO;
            end
            S_PSRCH_A:
            begin
                if (k_reg >= used_reg)
                begin
                    if (used_reg >= (9'd1 << width_reg) || used_reg >= 9'(PAL_DEPTH))
                        state_next = S_RB_INIT;
                    else
                    begin
                        pal_we = 1'b1;
                        pal_waddr = {pal_bank_reg, used_reg[7:0]};
                        pal_wdata = val_reg;
                        found_next = 16'(used_reg);
                        used_next = used_reg + 9'd1;
                        loc_w_next = width_reg;
                        state_next = S_LOC_GO;
                    end
                end
                else
                begin
                    pal_raddr = {pal_bank_reg, k_reg[7:0]};
                    state_next = S_PSRCH_C;
                end
            end
            S_PSRCH_C:
            begin
                if (pal_rdata_reg == val_reg)
                begin
                    found_next = 16'(k_reg);
                    loc_w_next = width_reg;
                    state_next = S_LOC_GO;
                end
                else
                begin
                    k_next = k_reg + 9'd1;
                    state_next = S_PSRCH_A;
                end
            end
            S_LOC_GO:
            begin
                loc_start = 1'b1;
                state_next = S_LOC;
            end
            S_LOC:
            begin
                if (loc_done)
                begin
                    word_next = loc.word;
                    shift_next = loc.shift;
                    if (mode_reg == MODE_SINGLE)
                    begin
                        // fresh bank: all zero except the new entry
                        ctr_next = 11'd0;
                        hit_en_next = 1'b1;
                        hit_word_next = loc.word;
                        hit_data_next = 64'd1 << loc.shift;
                        nx_mode_next = MODE_PALETTE;
                        new_w_next = loc_w_reg;
                        nx_used_next = 9'd2;
                        swap_pal_next = 1'b0;
                        state_next = S_CLR;
                    end
                    else state_next = S_WRD;
                end
            end
            S_WRD:
            begin
                pk_raddr = {pk_bank_reg, word_reg};
                state_next = S_WDAT;
            end
            S_WDAT:
            begin
                if (cmd_reg == CMD_GET)
                begin
                    if (mode_reg == MODE_DIRECT)
                    begin
                        rd_next = fld64[15:0];
                        state_next = S_DONE;
                    end
                    else
                    begin
                        pal_raddr = {pal_bank_reg, fld64[7:0]};
                        state_next = S_PDAT;
                    end
                end
                else
                begin
                    pk_we = 1'b1;
                    pk_waddr = {pk_bank_reg, word_reg};
                    pk_wdata = (pk_rdata_reg & ~(mask_w << shift_reg))
                        | ((64'(found_reg) & mask_w) << shift_reg);
                    state_next = S_DONE;
                end
            end
            S_PDAT:
            begin
                rd_next = pal_rdata_reg;
                state_next = S_DONE;
            end
            // rebuild, first pass: collect distinct values into the idle palette bank
            S_RB_INIT:
            begin
                e_next = 12'd0;
                wc_next = 10'd0;
                slot_next = 6'd0;
                sh_next = 6'd0;
                count_next = 9'd0;
                ovf_next = 1'b0;
                state_next = S_RB_WRD;
            end
            S_RB_WRD:
            begin
                pk_raddr = {pk_bank_reg, wc_reg};
                state_next = S_RB_WDAT;
            end
            S_RB_WDAT:
            begin
                pal_raddr = {pal_bank_reg, 8'((pk_rdata_reg >> sh_reg) & mask_w)};
                state_next = S_RB_PDAT;
            end
            S_RB_PDAT:
            begin
                v_next = (e_reg == idx_reg) ? val_reg : pal_rdata_reg;
                k_next = 9'd0;
                state_next = ovf_reg ? S_RB_SNAP : S_RB_SA;
            end
            S_RB_SA:
            begin
                if (k_reg >= count_reg)
                begin
                    if (count_reg < limit)
                    begin
                        pal_we = 1'b1;
                        pal_waddr = {~pal_bank_reg, count_reg[7:0]};
                        pal_wdata = v_reg;
                        snidx_next = count_reg[7:0];
                        count_next = count_reg + 9'd1;
                    end
                    else ovf_next = 1'b1;
                    state_next = S_RB_SNAP;
                end
                else
                begin
                    pal_raddr = {~pal_bank_reg, k_reg[7:0]};
                    state_next = S_RB_SC;
                end
            end
            S_RB_SC:
            begin
                if (pal_rdata_reg == v_reg)
                begin
                    snidx_next = k_reg[7:0];
                    state_next = S_RB_SNAP;
                end
                else
                begin
                    k_next = k_reg + 9'd1;
                    state_next = S_RB_SA;
                end
            end
            S_RB_SNAP:
            begin
                snap_we = 1'b1;
                snap_waddr = e_reg;
                snap_wdata = {snidx_reg, v_reg};
                if (e_reg == 12'd0) first_next = v_reg;
                if (e_last) state_next = S_RB_DECIDE;
                else
                begin
                    e_next = e_reg + 12'd1;
                    if ({1'b0, slot_reg} == per_old - 7'd1)
                    begin
                        slot_next = 6'd0;
                        sh_next = 6'd0;
                        wc_next = wc_reg + 10'd1;
                    end
                    else
                    begin
                        slot_next = slot_reg + 6'd1;
                        sh_next = sh_reg + width_reg[5:0];
                    end
                    state_next = S_RB_WRD;
                end
            end
            S_RB_DECIDE:
            begin
                if (!ovf_reg && count_reg == 9'd1)
                begin
                    mode_next = MODE_SINGLE;
                    width_next = 5'd0;
                    single_next = first_reg;
                    used_next = 9'd0;
                    state_next = S_DONE;
                end
                else
                begin
                    if (ovf_reg)
                    begin
                        new_w_next = w_dir;
                        nx_mode_next = MODE_DIRECT;
                        nx_used_next = 9'd0;
                    end
                    else
                    begin
                        new_w_next = {1'b0, (bf < w_lo) ? w_lo : bf};
                        nx_mode_next = MODE_PALETTE;
                        nx_used_next = count_reg;
                    end
                    swap_pal_next = !ovf_reg;
                    e_next = 12'd0;
                    wc_next = 10'd0;
                    slot_next = 6'd0;
                    sh_next = 6'd0;
                    acc_next = 64'd0;
                    state_next = S_RB_P2A;
                end
            end
            // second pass: pack the snapshot into the idle packed bank
            S_RB_P2A:
            begin
                snap_raddr = e_reg;
                state_next = S_RB_P2D;
            end
            S_RB_P2D:
            begin
                if (({1'b0, slot_reg} == per_new - 7'd1) || e_last)
                begin
                    pk_we = 1'b1;
                    pk_waddr = {~pk_bank_reg, wc_reg};
                    pk_wdata = acc_reg | acc_add;
                    acc_next = 64'd0;
                end
                else acc_next = acc_reg | acc_add;
                if (e_last)
                begin
                    ctr_next = {1'b0, wc_reg} + 11'd1;
                    hit_en_next = 1'b0;
                    state_next = S_CLR;
                end
                else
                begin
                    e_next = e_reg + 12'd1;
                    if ({1'b0, slot_reg} == per_new - 7'd1)
                    begin
                        slot_next = 6'd0;
                        sh_next = 6'd0;
                        wc_next = wc_reg + 10'd1;
                    end
                    else
                    begin
                        slot_next = slot_reg + 6'd1;
                        sh_next = sh_reg + new_w_reg[5:0];
                    end
                    state_next = S_RB_P2A;
                end
            end
            // zero idle packed bank from ctr_reg; swap it, palette if swap_pal
            S_CLR:
            begin
                if (ctr_reg[10])
                begin
                    pk_bank_next = ~pk_bank_reg;
                    if (swap_pal_reg) pal_bank_next = ~pal_bank_reg;
                    mode_next = nx_mode_reg;
                    width_next = new_w_reg;
                    used_next = nx_used_reg;
                    state_next = S_DONE;
                end
                else
                begin
                    pk_we = 1'b1;
                    pk_waddr = {~pk_bank_reg, ctr_reg[9:0]};
                    pk_wdata = (hit_en_reg && ctr_reg[9:0] == hit_word_reg)
                        ? hit_data_reg : 64'd0;
                    ctr_next = ctr_reg + 11'd1;
                end
            end
            S_DONE:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    o_val_next = rd_reg;
                    o_mode_next = mode_reg;
                    o_bits_next = width_reg;
                    o_pal_next = (mode_reg == MODE_PALETTE) ? used_reg : 9'd0;
                    out_valid_next = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            cnt_cfg_reg <= 13'd4096;
            min_cfg_reg <= 4'd4;
            max_cfg_reg <= 4'd8;
            dir_cfg_reg <= 5'd15;
            mode_reg <= MODE_SINGLE;
            width_reg <= 5'd0;
            single_reg <= 16'd0;
            used_reg <= 9'd0;
            pk_bank_reg <= 1'b0;
            pal_bank_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_cfg_reg <= cnt_cfg_next;
            min_cfg_reg <= min_cfg_next;
            max_cfg_reg <= max_cfg_next;
            dir_cfg_reg <= dir_cfg_next;
            mode_reg <= mode_next;
            width_reg <= width_next;
            single_reg <= single_next;
            used_reg <= used_next;
            pk_bank_reg <= pk_bank_next;
            pal_bank_reg <= pal_bank_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg <= cmd_next;
        idx_reg <= idx_next;
        val_reg <= val_next;
        loc_w_reg <= loc_w_next;
        word_reg <= word_next;
        shift_reg <= shift_next;
        found_reg <= found_next;
        k_reg <= k_next;
        rd_reg <= rd_next;
        o_val_reg <= o_val_next;
        o_mode_reg <= o_mode_next;
        o_bits_reg <= o_bits_next;
        o_pal_reg <= o_pal_next;
        e_reg <= e_next;
        wc_reg <= wc_next;
        slot_reg <= slot_next;
        sh_reg <= sh_next;
        count_reg <= count_next;
        ovf_reg <= ovf_next;
        v_reg <= v_next;
        snidx_reg <= snidx_next;
        first_reg <= first_next;
        new_w_reg <= new_w_next;
        acc_reg <= acc_next;
        ctr_reg <= ctr_next;
        hit_en_reg <= hit_en_next;
        hit_word_reg <= hit_word_next;
        hit_data_reg <= hit_data_next;
        nx_mode_reg <= nx_mode_next;
        nx_used_reg <= nx_used_next;
        swap_pal_reg <= swap_pal_next;
    end

    assign in_stall = (state_reg != S_IDLE);
    assign cfg_ready = 1'b1;
    assign out_valid = out_valid_reg;
    assign read_value = o_val_reg;
    assign storage_mode = o_mode_reg;
    assign bits_per_entry = o_bits_reg;
    assign palette_entries = o_pal_reg;

endmodule

`default_nettype wire
